@@ design/stre_pkg.sv @@
// ----------------------------------------------------------------------------
// stre_pkg: shared types and constants of the track record encoder
// Holds the channel payload structs, the queued job layout, the fixed record
// bytes and the constants of the divide-by-45 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stre_pkg;

    // Record layout.
    localparam int RECORD_LEN = 41;
    localparam int POS_W      = 6;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_LEN - 1);

    localparam logic [7:0]  CAT_BYTE   = 8'd62;
    localparam logic [15:0] REC_LEN16  = 16'(RECORD_LEN);
    localparam logic [31:0] FIELD_MAP  = 32'hB9B1_6108;
    localparam logic [7:0]  SPARE_BYTE = 8'h00;
    localparam logic [7:0]  EXT_HDR    = 8'h89;
    localparam logic [7:0]  EXT1_BASE  = 8'h01;
    localparam logic [7:0]  EXT1_NEW   = 8'h20;
    localparam logic [7:0]  EXT1_END   = 8'h40;
    localparam logic [7:0]  EXT2_BYTE  = 8'h01;
    localparam logic [7:0]  AGE_HDR    = 8'h81;
    localparam logic [7:0]  AGE_BYTE1  = 8'h00;
    localparam logic [7:0]  AGE_BYTE2  = 8'h04;

    // Callsign and status characters.
    localparam logic [7:0] CS_NUL  = 8'h00;
    localparam logic [7:0] CS_PAD  = 8'h20;
    localparam logic [7:0] CH_NEW  = 8'h4E;
    localparam logic [7:0] CH_END  = 8'h44;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIC = 1'b1;
    localparam logic [7:0] SAC_RESET = 8'd148;
    localparam logic [7:0] SIC_RESET = 8'd1;

    // Divide by 45 through a reciprocal: q0 = (x * DIV_MULT) >> DIV_SHIFT is
    // the quotient or one less for any x below 2^DIV_IN_W.
    localparam int DIV_IN_W  = 30;
    localparam int DIV_M_W   = 31;
    localparam int DIV_SHIFT = 36;
    localparam int DIV_Q_W   = DIV_IN_W + DIV_M_W - DIV_SHIFT;
    localparam logic [DIV_M_W-1:0]  DIV_MULT    = 31'd1527099483;
    localparam logic [DIV_IN_W-1:0] DIV_DIVISOR = 30'd45;

    // Job queue.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    typedef struct packed {
        logic [15:0] track_number;
        logic [23:0] latitude;
        logic [24:0] longitude;
        logic [16:0] altitude;
        logic [63:0] callsign;
        logic [16:0] ground_speed;
        logic [15:0] heading;
        logic [7:0]  status_char;
        logic [3:0]  target_type;
        logic [7:0]  quality;
        logic [22:0] time_seconds;
    } t_in;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       last_byte;
    } t_out;

    // One report after conversion, as the back end serializes it.
    typedef struct packed {
        logic [23:0] time_code;
        logic [15:0] track_number;
        logic [23:0] lat_code;
        logic [23:0] lon_code;
        logic [15:0] alt_code;
        logic [47:0] callsign_code;
        logic [15:0] speed_code;
        logic [15:0] heading_code;
        logic [7:0]  ext1;
        logic [3:0]  target_type;
        logic [7:0]  quality;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

@@ design/surveillance_track_record_encoder.sv @@
// ----------------------------------------------------------------------------
// surveillance_track_record_encoder: track report to 41-byte track record
// Converts each track report and sends the record one byte per cycle unless
// stalled, with the last byte marked. Holds the two data source registers.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    stre_pkg::t_in (report)
//   out       output     o_out_valid / i_out_stall  stre_pkg::t_out (one byte)
//   cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A report passes the three conversion stages and is then pushed into the job
// queue; an idle serializer pops it and presents its first byte through the
// output register. Each record is 41 bytes sent back to back, so the output port
// sets the sustained rate. Reports keep being taken until the two-entry queue
// is full and a job waits in the last stage. Reset is synchronous and active
// low; it empties the pipeline and the queue and restores the source registers.
// ----------------------------------------------------------------------------
`default_nettype none

module surveillance_track_record_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire stre_pkg::t_in                     i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output stre_pkg::t_out                         o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [stre_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [7:0]                        i_cfg_data
);

    logic [7:0]        r_sac, r_sic;
    logic              w_push, w_pop;
    stre_pkg::t_job    w_push_job, w_head_job;
    stre_pkg::t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sac <= stre_pkg::SAC_RESET;
            r_sic <= stre_pkg::SIC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stre_pkg::CFG_SAC: r_sac <= i_cfg_data;
                stre_pkg::CFG_SIC: r_sic <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    stre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    stre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_stat  (w_q_stat)
    );

    stre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_head_job),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .i_sac       (r_sac),
        .i_sic       (r_sic),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ design/stre_div45.sv @@
// ----------------------------------------------------------------------------
// stre_div45: two-stage unsigned divide by 45
// Stage one forms the reciprocal product, stage two takes the estimate and
// adds one where the remainder is still 45 or more.
// ----------------------------------------------------------------------------
`default_nettype none

module stre_div45 (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [stre_pkg::DIV_IN_W-1:0] i_x,
    output logic      [stre_pkg::DIV_Q_W-1:0]  o_q
);

    logic [stre_pkg::DIV_IN_W-1:0]                    r_x;
    logic [stre_pkg::DIV_IN_W+stre_pkg::DIV_M_W-1:0]  r_prod;
    logic [stre_pkg::DIV_Q_W-1:0]                     r_q;
    logic [stre_pkg::DIV_Q_W-1:0]                     w_q0;
    logic [stre_pkg::DIV_IN_W-1:0]                    w_q45;
    logic [stre_pkg::DIV_IN_W-1:0]                    w_rem;
    logic [stre_pkg::DIV_Q_W-1:0]                     n_q;

    always_comb begin
        w_q0  = r_prod[stre_pkg::DIV_SHIFT +: stre_pkg::DIV_Q_W];
        w_q45 = stre_pkg::DIV_IN_W'({w_q0, 5'b0}) + stre_pkg::DIV_IN_W'({w_q0, 3'b0})
              + stre_pkg::DIV_IN_W'({w_q0, 2'b0}) + stre_pkg::DIV_IN_W'(w_q0);
        w_rem = r_x - w_q45;
        n_q   = (w_rem >= stre_pkg::DIV_DIVISOR) ? w_q0 + 1'b1 : w_q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= i_x;
            r_prod <= {{stre_pkg::DIV_M_W{1'b0}}, i_x}
                    * {{stre_pkg::DIV_IN_W{1'b0}}, stre_pkg::DIV_MULT};
            r_q    <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

@@ design/stre_front.sv @@
// ----------------------------------------------------------------------------
// stre_front: request intake and field conversion
// A three-stage pipeline that converts one report into a job: scaling,
// rounding toward zero and callsign packing, then pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stre_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire stre_pkg::t_in     i_in,
    input  wire stre_pkg::t_q_stat i_q_stat,
    output logic                   o_push,
    output stre_pkg::t_job         o_job
);

    typedef struct packed {
        logic [23:0] time_code;
        logic [15:0] track_number;
        logic [15:0] alt_code;
        logic [47:0] callsign_code;
        logic [15:0] speed_code;
        logic [7:0]  ext1;
        logic [3:0]  target_type;
        logic [7:0]  quality;
        logic        lat_neg;
        logic        lon_neg;
    } t_side;

    logic  r_v1, r_v2, r_v3;
    t_side r_s1, r_s2, r_s3;
    t_side n_s1;
    logic [stre_pkg::DIV_IN_W-1:0] r_lat_x, r_lon_x, r_hdg_x;
    logic [stre_pkg::DIV_IN_W-1:0] n_lat_x, n_lon_x, n_hdg_x;
    logic [stre_pkg::DIV_Q_W-1:0]  w_lat_q, w_lon_q, w_hdg_q;
    logic w_adv;
    logic w_accept;

    assign w_adv      = !r_v3 || !i_q_stat.full;
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;
    assign o_push     = r_v3 && !i_q_stat.full;

    always_comb begin
        logic [23:0] lat_mag;
        logic [24:0] lon_mag;
        logic [16:0] alt_sum;
        logic [20:0] spd_x10;
        logic [7:0]  ch;
        logic        ended;
        lat_mag = i_in.latitude[23]  ? 24'(-i_in.latitude)  : i_in.latitude;
        lon_mag = i_in.longitude[24] ? 25'(-i_in.longitude) : i_in.longitude;
        n_lat_x = {1'b0, lat_mag, 5'b0};
        n_lon_x = {lon_mag, 5'b0};
        n_hdg_x = {8'b0, i_in.heading, 6'b0};

        n_s1.time_code    = {i_in.time_seconds[16:0], 7'b0};
        n_s1.track_number = i_in.track_number;
        // Halving rounds toward zero, so negative values get one added first.
        alt_sum = i_in.altitude + {16'b0, i_in.altitude[16]};
        n_s1.alt_code = alt_sum[16:1];
        spd_x10 = {i_in.ground_speed, 3'b0} + {3'b0, i_in.ground_speed, 1'b0};
        n_s1.speed_code = spd_x10[19:4];

        // Once a NUL is seen, it and every later character become spaces.
        ended = 1'b0;
        n_s1.callsign_code = '0;
        for (int i = 0; i < 8; i++) begin
            ch = i_in.callsign[63-8*i -: 8];
            if (ch == stre_pkg::CS_NUL) begin
                ended = 1'b1;
            end
            if (ended) begin
                ch = stre_pkg::CS_PAD;
            end
            n_s1.callsign_code[47-6*i -: 6] = ch[5:0];
        end

        n_s1.ext1 = stre_pkg::EXT1_BASE
                  | ((i_in.status_char == stre_pkg::CH_NEW) ? stre_pkg::EXT1_NEW : 8'h00)
                  | ((i_in.status_char == stre_pkg::CH_END) ? stre_pkg::EXT1_END : 8'h00);
        n_s1.target_type = i_in.target_type;
        n_s1.quality     = i_in.quality;
        n_s1.lat_neg     = i_in.latitude[23];
        n_s1.lon_neg     = i_in.longitude[24];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1    <= n_s1;
            r_lat_x <= n_lat_x;
            r_lon_x <= n_lon_x;
            r_hdg_x <= n_hdg_x;
            r_s2    <= r_s1;
            r_s3    <= r_s2;
        end
    end

    stre_div45 u_div_lat (.i_clk(i_clk), .i_en(w_adv), .i_x(r_lat_x), .o_q(w_lat_q));
    stre_div45 u_div_lon (.i_clk(i_clk), .i_en(w_adv), .i_x(r_lon_x), .o_q(w_lon_q));
    stre_div45 u_div_hdg (.i_clk(i_clk), .i_en(w_adv), .i_x(r_hdg_x), .o_q(w_hdg_q));

    always_comb begin
        o_job.time_code     = r_s3.time_code;
        o_job.track_number  = r_s3.track_number;
        o_job.lat_code      = r_s3.lat_neg ? 24'(-w_lat_q) : w_lat_q[23:0];
        o_job.lon_code      = r_s3.lon_neg ? 24'(-w_lon_q) : w_lon_q[23:0];
        o_job.alt_code      = r_s3.alt_code;
        o_job.callsign_code = r_s3.callsign_code;
        o_job.speed_code    = r_s3.speed_code;
        o_job.heading_code  = w_hdg_q[15:0];
        o_job.ext1          = r_s3.ext1;
        o_job.target_type   = r_s3.target_type;
        o_job.quality       = r_s3.quality;
    end

`ifndef ASSERT_OFF
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_q_stat.full) |=> (r_v3 && $stable(r_s3)))
        else $error("front: blocked job changed while the queue was full");
`endif

endmodule

`default_nettype wire

@@ design/stre_queue.sv @@
// ----------------------------------------------------------------------------
// stre_queue: two-entry job queue
// Decouples the conversion pipeline from the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module stre_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire stre_pkg::t_job    i_data,
    input  wire logic              i_pop,
    output stre_pkg::t_job         o_data,
    output stre_pkg::t_q_stat      o_stat
);

    stre_pkg::t_job r_mem [stre_pkg::QDEPTH];
    logic [stre_pkg::QAW-1:0] r_wptr, r_rptr;
    logic [stre_pkg::QCW-1:0] r_count;
    logic w_do_pop;

    assign o_stat.full  = (r_count == stre_pkg::QCW'(stre_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rptr];
    assign w_do_pop     = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue: push while full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stre_pkg::QCW'(stre_pkg::QDEPTH))
        else $error("queue: fill count beyond depth");
`endif

endmodule

`default_nettype wire

@@ design/stre_back.sv @@
// ----------------------------------------------------------------------------
// stre_back: record serializer
// Holds the current job, assembles the 41-byte record and sends it one byte
// per cycle unless stalled, via an output register, with no gap between jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module stre_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire stre_pkg::t_job    i_q_data,
    input  wire stre_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    input  wire logic [7:0]        i_sac,
    input  wire logic [7:0]        i_sic,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output stre_pkg::t_out         o_out
);

    logic                         r_busy;
    logic [stre_pkg::POS_W-1:0]   r_pos;
    stre_pkg::t_job               r_job;
    logic                         r_out_valid;
    stre_pkg::t_out               r_out;
    logic [0:stre_pkg::RECORD_LEN-1][7:0] w_rec;
    logic w_adv;
    logic w_last;
    logic w_step;

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_step = w_adv && r_busy;
    assign w_last = (r_pos == stre_pkg::LAST_POS);
    assign o_pop  = !i_q_stat.empty && (!r_busy || (w_step && w_last));

    always_comb begin
        w_rec = {stre_pkg::CAT_BYTE, stre_pkg::REC_LEN16, stre_pkg::FIELD_MAP,
                 i_sac, i_sic, r_job.time_code, r_job.track_number,
                 r_job.lat_code, r_job.lon_code, r_job.alt_code,
                 stre_pkg::SPARE_BYTE, r_job.callsign_code,
                 r_job.speed_code, r_job.heading_code,
                 stre_pkg::EXT_HDR, r_job.ext1, stre_pkg::EXT2_BYTE,
                 {3'b0, r_job.target_type, 1'b0},
                 stre_pkg::AGE_HDR, stre_pkg::AGE_BYTE1, stre_pkg::AGE_BYTE2,
                 r_job.quality};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_busy;
            end
            if (w_step) begin
                r_pos <= w_last ? '0 : r_pos + 1'b1;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_step && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_data;
        end
        if (w_step) begin
            r_out.record_byte <= w_rec[r_pos];
            r_out.last_byte   <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> r_busy)
        else $error("back: byte position moved without a held record");
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (r_out.last_byte == ($past(r_pos) == stre_pkg::LAST_POS)))
        else $error("back: last byte mark does not match the byte position");
`endif

endmodule

`default_nettype wire
